### src/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types, codes and defaults of the cooperative task scheduler.
// ----------------------------------------------------------------------------
package cts_pkg;

    // defaults for the top level parameters
    localparam int NUM_SLOTS_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 2;

    // due results reported per tick at most
    localparam int          DUE_N_W = 4;
    localparam logic [3:0]  MAX_DUE = 4'd8;

    // input opcodes
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_DEL  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // result kinds
    localparam logic [2:0] K_ADDED   = 3'd0;
    localparam logic [2:0] K_FULL    = 3'd1;
    localparam logic [2:0] K_DELETED = 3'd2;
    localparam logic [2:0] K_UNDEF   = 3'd3;
    localparam logic [2:0] K_DUE     = 3'd4;
    localparam logic [2:0] K_IDLE    = 3'd5;

    // input item
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] target_slot;
        logic [7:0] start_delay;
        logic [7:0] period_ticks;
    } t_cmd;

    // result item
    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] slot;
        logic       last;
    } t_result;

    // classified job, as queued between front and back
    typedef enum logic [1:0] {
        JOB_ADD,
        JOB_DEL,
        JOB_TICK
    } t_job_op;

    typedef struct packed {
        t_job_op    op;
        logic       in_range;    // delete target lies inside the table
        logic [7:0] target;
        logic [7:0] count_init;  // start delay plus one, wrapping
        logic [7:0] period;
    } t_job;

    // queue status seen by the back end
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_stat;

    // back end sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WALK,
        BK_FIN
    } t_bk_state;

endpackage

### src/cts_ram.sv
// ----------------------------------------------------------------------------
// cts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/cts_front.sv
// ----------------------------------------------------------------------------
// cts_front
// Accepts command items, classifies them and pushes jobs into the queue.
// ----------------------------------------------------------------------------
module cts_front #(
    parameter int NUM_SLOTS = cts_pkg::NUM_SLOTS_DEF
) (
    input  logic                 i_start,
    input  cts_pkg::t_cmd        i_cmd,
    input  cts_pkg::t_queue_stat i_q_stat,
    output logic                 o_busy,
    output logic                 o_push,
    output cts_pkg::t_job        o_job
);

    import cts_pkg::*;

    logic accept;

    assign o_busy = i_q_stat.full;
    assign accept = i_start & ~i_q_stat.full;

    // classify; the unused opcode is taken and dropped
    always_comb begin
        o_push           = 1'b0;
        o_job.op         = JOB_TICK;
        o_job.in_range   = ({1'b0, i_cmd.target_slot} < 9'(NUM_SLOTS));
        o_job.target     = i_cmd.target_slot;
        o_job.count_init = i_cmd.start_delay + 8'd1;
        o_job.period     = i_cmd.period_ticks;
        case (i_cmd.opcode)
            OP_ADD: begin
                o_job.op = JOB_ADD;
                o_push   = accept;
            end
            OP_DEL: begin
                o_job.op = JOB_DEL;
                o_push   = accept;
            end
            OP_TICK: begin
                o_job.op = JOB_TICK;
                o_push   = accept;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

### src/cts_queue.sv
// ----------------------------------------------------------------------------
// cts_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module cts_queue #(
    parameter int DEPTH = cts_pkg::QUEUE_DEPTH_DEF,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  cts_pkg::t_job        i_job,
    input  logic                 i_pop,
    output cts_pkg::t_job        o_job,
    output cts_pkg::t_queue_stat o_stat
);

    import cts_pkg::*;

    t_job          r_buf [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign do_push      = i_push & ~o_stat.full;
    assign do_pop       = i_pop & ~o_stat.empty;
    assign o_job        = r_buf[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr_ptr] <= i_job;
        end
    end

endmodule

### src/cts_back.sv
// ----------------------------------------------------------------------------
// cts_back
// Executes queued jobs against the slot table and drives the results.
// ----------------------------------------------------------------------------
module cts_back #(
    parameter int NUM_SLOTS = cts_pkg::NUM_SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cts_pkg::t_job        i_job,
    input  cts_pkg::t_queue_stat i_q_stat,
    output logic                 o_pop,
    output logic                 o_valid,
    output cts_pkg::t_result     o_result
);

    import cts_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    // control state
    t_bk_state             r_state, n_state;
    logic [NUM_SLOTS-1:0]  r_valid, n_valid;
    logic [CNT_W-1:0]      r_next_free, n_next_free;
    logic                  r_rd_on, n_rd_on;
    logic [SLOT_W-1:0]     r_rd_idx, n_rd_idx;
    logic                  r_ex_on, n_ex_on;
    logic [SLOT_W-1:0]     r_ex_idx, n_ex_idx;
    logic                  r_pend_on, n_pend_on;
    logic [SLOT_W-1:0]     r_pend_slot, n_pend_slot;
    logic [DUE_N_W-1:0]    r_due_n, n_due_n;
    logic                  r_out_vld, n_out_vld;
    t_result               r_out, n_out;

    // table RAM: {countdown, period}
    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_waddr;
    logic [15:0]           ram_wdata;
    logic [SLOT_W-1:0]     ram_raddr;
    logic [15:0]           ram_rdata;

    // walk stage values
    logic                  ex_valid;
    logic [7:0]            ex_dec;
    logic [7:0]            ex_per;
    logic [7:0]            pend_wide;
    logic [7:0]            free_wide;

    cts_ram #(
        .WIDTH (16),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ex_valid  = r_valid[r_ex_idx];
    assign ex_dec    = ram_rdata[15:8] - 8'd1;
    assign ex_per    = ram_rdata[7:0];
    assign pend_wide = 8'(r_pend_slot);
    assign free_wide = 8'(r_next_free);

    // sequencer: next state and outputs
    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_next_free = r_next_free;
        n_rd_on     = r_rd_on;
        n_rd_idx    = r_rd_idx;
        n_ex_on     = r_ex_on;
        n_ex_idx    = r_ex_idx;
        n_pend_on   = r_pend_on;
        n_pend_slot = r_pend_slot;
        n_due_n     = r_due_n;
        n_out_vld   = 1'b0;
        n_out       = r_out;
        o_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_ex_idx;
        ram_wdata   = {ex_dec, ex_per};
        ram_raddr   = r_rd_idx;

        case (r_state)
            BK_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    case (i_job.op)
                        JOB_ADD: begin
                            n_out_vld = 1'b1;
                            if (r_next_free < CNT_W'(NUM_SLOTS)) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_next_free[SLOT_W-1:0];
                                ram_wdata = {i_job.count_init, i_job.period};
                                n_valid[r_next_free[SLOT_W-1:0]] = 1'b1;
                                n_next_free = r_next_free + 1'b1;
                                n_out = '{kind: K_ADDED, slot: free_wide[2:0], last: 1'b1};
                            end else begin
                                n_out = '{kind: K_FULL, slot: 3'd0, last: 1'b1};
                            end
                        end
                        JOB_DEL: begin
                            n_out_vld = 1'b1;
                            if (i_job.in_range && r_valid[i_job.target[SLOT_W-1:0]]) begin
                                n_valid[i_job.target[SLOT_W-1:0]] = 1'b0;
                                n_out = '{kind: K_DELETED, slot: i_job.target[2:0],
                                          last: 1'b1};
                            end else begin
                                n_out = '{kind: K_UNDEF, slot: 3'd0, last: 1'b1};
                            end
                        end
                        JOB_TICK: begin
                            n_state   = BK_WALK;
                            n_rd_on   = 1'b1;
                            n_rd_idx  = '0;
                            n_ex_on   = 1'b0;
                            n_pend_on = 1'b0;
                            n_due_n   = '0;
                        end
                        default: begin
                            n_state = BK_IDLE;
                        end
                    endcase
                end
            end

            BK_WALK: begin
                // read stage: one slot per cycle
                n_ex_on  = r_rd_on;
                n_ex_idx = r_rd_idx;
                if (r_rd_on) begin
                    if (r_rd_idx == LAST_SLOT) begin
                        n_rd_on = 1'b0;
                    end else begin
                        n_rd_idx = r_rd_idx + 1'b1;
                    end
                end
                // update stage: decrement, reload or retire, report
                if (r_ex_on) begin
                    if (ex_valid) begin
                        ram_we = 1'b1;
                        if (ex_dec == 8'd0) begin
                            ram_wdata = {ex_per, ex_per};
                            if (ex_per == 8'd0) begin
                                n_valid[r_ex_idx] = 1'b0;
                            end
                            if (r_due_n < MAX_DUE) begin
                                // hold the newest due slot back to mark the last one
                                if (r_pend_on) begin
                                    n_out_vld = 1'b1;
                                    n_out = '{kind: K_DUE, slot: pend_wide[2:0], last: 1'b0};
                                end
                                n_pend_on   = 1'b1;
                                n_pend_slot = r_ex_idx;
                                n_due_n     = r_due_n + 1'b1;
                            end
                        end
                    end
                    if (r_ex_idx == LAST_SLOT) begin
                        n_state = BK_FIN;
                    end
                end
            end

            BK_FIN: begin
                n_out_vld = 1'b1;
                if (r_pend_on) begin
                    n_out = '{kind: K_DUE, slot: pend_wide[2:0], last: 1'b1};
                end else begin
                    n_out = '{kind: K_IDLE, slot: 3'd0, last: 1'b1};
                end
                n_pend_on = 1'b0;
                n_ex_on   = 1'b0;
                n_state   = BK_IDLE;
            end

            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_valid     <= '0;
            r_next_free <= '0;
            r_rd_on     <= 1'b0;
            r_ex_on     <= 1'b0;
            r_pend_on   <= 1'b0;
            r_due_n     <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_next_free <= n_next_free;
            r_rd_on     <= n_rd_on;
            r_ex_on     <= n_ex_on;
            r_pend_on   <= n_pend_on;
            r_due_n     <= n_due_n;
            r_out_vld   <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx    <= n_rd_idx;
        r_ex_idx    <= n_ex_idx;
        r_pend_slot <= n_pend_slot;
        r_out       <= n_out;
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

### src/cooperative_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// cooperative_task_scheduler_top
// Time-triggered cooperative scheduler over a table of task slots.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy rises only
// when the job queue (QUEUE_DEPTH entries) is full. Results appear on
// o_result for one cycle each, marked by o_valid, and cannot be held off.
// The back end takes one queued job at a time. Add and delete give their
// result in the cycle after the job leaves the queue. A tick walks the slot
// table through its single read port, one slot per cycle, and occupies the
// back end until it ends; its due results come out during the walk and the
// final one (or the idle result) at its end. The unused opcode is taken and
// gives no result.
// ----------------------------------------------------------------------------
module cooperative_task_scheduler_top #(
    parameter int NUM_SLOTS   = cts_pkg::NUM_SLOTS_DEF,
    parameter int QUEUE_DEPTH = cts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  cts_pkg::t_cmd    i_cmd,
    output logic             o_valid,
    output cts_pkg::t_result o_result
);

    import cts_pkg::*;

    t_job        push_job;
    t_job        head_job;
    t_queue_stat q_stat;
    logic        push;
    logic        pop;

    // accept and classify
    cts_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .i_start  (start),
        .i_cmd    (i_cmd),
        .i_q_stat (q_stat),
        .o_busy   (busy),
        .o_push   (push),
        .o_job    (push_job)
    );

    // decoupling queue
    cts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    // slot table and execution
    cts_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (head_job),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
